FILE: hdl/jsrt_pkg.sv
// ----------------------------------------------------------------------------
// jsrt_pkg
// Shared widths, constants, register codes, controller states and the
// command/status bundles of the joint slew-rate tracker.
// ----------------------------------------------------------------------------
package jsrt_pkg;

  localparam int JOINT_COUNT_DEF = 6;
  localparam int MAX_JOINTS      = 8;

  localparam int JOINT_W    = 3;
  localparam int ANGLE_W    = 32;
  localparam int STEP_W     = 31;
  localparam int TPS_W      = 20;
  localparam int TOL_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  // Angle wrap: remainder width and number of restoring steps
  localparam int REM_W      = 33;
  localparam int WRAP_STEPS = 6;
  localparam int WCNT_W     = 3;

  // Error, summed error and velocity product widths
  localparam int ERR_W  = 33;
  localparam int SUM_W  = 36;
  localparam int PROD_W = 54;

  // pi and 2pi in Q8.24, rounded to nearest
  localparam logic [REM_W-1:0] Q_PI     = 33'd52707179;
  localparam logic [REM_W-1:0] Q_TWO_PI = 33'd105414357;

  localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 31'd167772;
  localparam logic [TPS_W-1:0]  TPS_RST        = 20'd1000;
  localparam logic [TOL_W-1:0]  REACH_TOL_RST  = 31'd167772;

  localparam logic signed [PROD_W-1:0] SAT_HI = 54'sh7FFFFFFF;
  localparam logic signed [PROD_W-1:0] SAT_LO = -54'sh80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_LIMIT = 2'd0,
    CFG_TICK_RATE  = 2'd1,
    CFG_REACH_TOL  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_PLACE,
    ST_SUM,
    ST_CHECK,
    ST_STEP,
    ST_MUL,
    ST_SEND
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic wrap_step;
    logic place;
    logic sum_acc;
    logic check;
    logic step;
    logic mul;
    logic send;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_tick;
    logic in_ok;
    logic wrap_last;
    logic joint_last;
    logic reach;
    logic done;
    logic out_free;
  } sts_t;

  // Clamp to the 32-bit signed range
  function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [ANGLE_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[ANGLE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[ANGLE_W-1:0];
    end else begin
      r = v[ANGLE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/jsrt_ctrl.sv
// ----------------------------------------------------------------------------
// jsrt_ctrl
// Sequencer of the tracker: goal wrap and placement, error sum, reached
// test, per-joint step, velocity multiply and result transfer.
// ----------------------------------------------------------------------------
module jsrt_ctrl
  import jsrt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   s_tvalid,
  output logic   s_tready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (sts.in_tick) begin
            state_next = ST_SUM;
          end else if (sts.in_ok) begin
            state_next = ST_WRAP;
          end
        end
      end
      ST_WRAP: begin
        if (sts.wrap_last) state_next = ST_PLACE;
      end
      ST_PLACE: state_next = ST_IDLE;
      ST_SUM: begin
        if (sts.joint_last) state_next = ST_CHECK;
      end
      ST_CHECK: state_next = sts.reach ? ST_SEND : ST_STEP;
      ST_STEP:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_SEND;
      ST_SEND: begin
        if (sts.out_free) begin
          if (sts.joint_last) begin
            state_next = ST_IDLE;
          end else if (sts.done) begin
            state_next = ST_SEND;
          end else begin
            state_next = ST_STEP;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_WRAP:  cmd.wrap_step = 1'b1;
      ST_PLACE: cmd.place     = 1'b1;
      ST_SUM:   cmd.sum_acc   = 1'b1;
      ST_CHECK: cmd.check     = 1'b1;
      ST_STEP:  cmd.step      = 1'b1;
      ST_MUL:   cmd.mul       = 1'b1;
      ST_SEND:  cmd.send      = sts.out_free;
      default: begin
        cmd      = '0;
        s_tready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A stalled result must never be overwritten
  a_send_free: assert property (@(posedge clk) disable iff (rst)
    cmd.send |-> sts.out_free)
    else $error("result loaded while previous one still pending");

  // The reached test is followed by a step or a transfer, never idle
  a_check_next: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |=> (state == ST_SEND || state == ST_STEP))
    else $error("reached test not followed by joint walk");

  // Input is taken only while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == ST_IDLE))
    else $error("input ready outside idle");
`endif

endmodule

FILE: hdl/jsrt_dp.sv
// ----------------------------------------------------------------------------
// jsrt_dp
// Datapath of the tracker: configuration registers, joint position and
// target registers, angle wrap unit, error accumulator, slew step,
// velocity multiplier and the result register.
// ----------------------------------------------------------------------------
module jsrt_dp
  import jsrt_pkg::*;
#(
  parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // Input payload
  input  logic [IN_TDATA_W-1:0]    s_tdata,   // joint[2:0], goal_angle[34:3]
  input  logic                     s_tuser,   // opcode
  // Result channel
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_TDATA_W-1:0]   m_tdata,   // joint_index, position, velocity
  output logic                     m_tuser,   // reached
  output logic                     m_tlast,
  // Controller link
  input  cmd_t                     cmd,
  output sts_t                     sts
);

  localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  logic [STEP_W-1:0] step_limit;
  logic [TPS_W-1:0]  ticks_per_second;
  logic [TOL_W-1:0]  reach_tolerance;

  logic signed [ANGLE_W-1:0] joint_position [JOINT_COUNT];
  logic signed [ANGLE_W-1:0] joint_target   [JOINT_COUNT];

  logic [JOINT_W-1:0]       ld_joint;
  logic [REM_W-1:0]         rem;
  logic [WCNT_W-1:0]        wcnt;
  logic [JW-1:0]            cnt;
  logic [SUM_W-1:0]         err_sum;
  logic                     done;
  logic signed [ERR_W-1:0]  dstep;
  logic signed [PROD_W-1:0] prod;

  logic                     out_valid;
  logic [JOINT_W-1:0]       out_joint;
  logic signed [ANGLE_W-1:0] out_pos;
  logic signed [ANGLE_W-1:0] out_vel;
  logic                     out_reached;
  logic                     out_last;

  logic [REM_W-1:0]          rem_init;
  logic [REM_W-1:0]          rem_sub;
  logic signed [ANGLE_W-1:0] tgt_new;
  logic signed [ERR_W-1:0]   err;
  logic [ERR_W-1:0]          err_abs;
  logic signed [ANGLE_W-1:0] pos_new;
  logic signed [ERR_W-1:0]   dstep_new;
  logic signed [ANGLE_W-1:0] vel_new;
  logic                      joint_last;
  logic                      reach;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit       <= STEP_LIMIT_RST;
      ticks_per_second <= TPS_RST;
      reach_tolerance  <= REACH_TOL_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_STEP_LIMIT: step_limit       <= cfg_data[STEP_W-1:0];
        CFG_TICK_RATE:  ticks_per_second <= cfg_data[TPS_W-1:0];
        CFG_REACH_TOL:  reach_tolerance  <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Shift goal by pi and lift negatives into range before the reduction
  always_comb begin
    logic signed [REM_W:0] r;
    r = (REM_W+1)'($signed(s_tdata[JOINT_W +: ANGLE_W])) + $signed({1'b0, Q_PI});
    if (r < 0) begin
      r = r + $signed({1'b0, Q_TWO_PI << (WRAP_STEPS - 1)});
    end
    rem_init = r[REM_W-1:0];
  end

  // One restoring step of the reduction modulo 2pi
  always_comb begin
    logic [REM_W-1:0] m;
    m = Q_TWO_PI << wcnt;
    rem_sub = (rem >= m) ? (rem - m) : rem;
  end

  // Pick the shortest-arc target from the wrapped goal
  always_comb begin
    logic signed [REM_W:0] w;
    logic signed [REM_W:0] d;
    logic signed [REM_W:0] pi_s;
    logic signed [REM_W:0] two_s;
    logic signed [REM_W:0] t;
    pi_s  = $signed({1'b0, Q_PI});
    two_s = $signed({1'b0, Q_TWO_PI});
    w     = $signed({1'b0, rem}) - pi_s;
    d     = w - (REM_W+1)'(joint_position[ld_joint[JW-1:0]]);
    if (d > pi_s) begin
      t = w - two_s;
    end else if (d < -pi_s) begin
      t = w + two_s;
    end else begin
      t = w;
    end
    tgt_new = sat32(PROD_W'(t));
  end

  // Per-joint error, its magnitude and the clamped step
  always_comb begin
    logic signed [ERR_W-1:0] lim;
    logic signed [ERR_W-1:0] d;
    err     = ERR_W'(joint_target[cnt]) - ERR_W'(joint_position[cnt]);
    err_abs = (err < 0) ? ERR_W'(-err) : ERR_W'(err);
    lim     = $signed({2'b00, step_limit});
    if (err > lim) begin
      d = lim;
    end else if (err < -lim) begin
      d = -lim;
    end else begin
      d = err;
    end
    pos_new   = sat32(PROD_W'(joint_position[cnt]) + PROD_W'(d));
    dstep_new = ERR_W'(pos_new) - ERR_W'(joint_position[cnt]);
  end

  assign vel_new    = done ? '0 : sat32(prod);
  assign joint_last = (cnt == JW'(JOINT_COUNT - 1));
  assign reach      = (err_sum <= SUM_W'(reach_tolerance));

  // Joint state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        joint_position[i] <= '0;
        joint_target[i]   <= '0;
      end
    end else begin
      if (cmd.place) joint_target[ld_joint[JW-1:0]] <= tgt_new;
      if (cmd.step)  joint_position[cnt] <= pos_new;
    end
  end

  // Item capture, wrap unit, accumulator and step registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ld_joint <= s_tdata[JOINT_W-1:0];
      rem      <= rem_init;
      wcnt     <= WCNT_W'(WRAP_STEPS - 1);
      err_sum  <= '0;
    end
    if (cmd.wrap_step) begin
      rem  <= rem_sub;
      wcnt <= wcnt - WCNT_W'(1);
    end
    if (cmd.sum_acc) err_sum <= err_sum + SUM_W'(err_abs);
    if (cmd.check)   done <= reach;
    if (cmd.step)    dstep <= dstep_new;
    if (cmd.mul)     prod <= dstep * $signed({1'b0, ticks_per_second});
  end

  // Joint counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.capture || cmd.check) begin
      cnt <= '0;
    end else if (cmd.sum_acc || cmd.send) begin
      cnt <= joint_last ? '0 : cnt + JW'(1);
    end
  end

  // Result register: load on send, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.send) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      out_joint   <= JOINT_W'(cnt);
      out_pos     <= joint_position[cnt];
      out_vel     <= vel_new;
      out_reached <= done;
      out_last    <= joint_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_vel, out_pos, out_joint};
  assign m_tuser  = out_reached;
  assign m_tlast  = out_last;

  // Status back to the controller
  always_comb begin
    sts.in_tick    = (opcode_t'(s_tuser) == OP_TICK);
    sts.in_ok      = ({1'b0, s_tdata[JOINT_W-1:0]} < (JOINT_W+1)'(JOINT_COUNT));
    sts.wrap_last  = (wcnt == '0);
    sts.joint_last = joint_last;
    sts.reach      = reach;
    sts.done       = done;
    sts.out_free   = !out_valid || m_tready;
  end

`ifndef SYNTHESIS
  // A send always leaves a result waiting
  a_send_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.send |=> m_tvalid)
    else $error("send did not raise result valid");

  // A reached report carries zero velocity
  a_reached_still: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (out_vel == '0))
    else $error("reached joint reports motion");

  // Reported joint lies within the configured joint count
  a_joint_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, out_joint} < (JOINT_W+1)'(JOINT_COUNT)))
    else $error("result joint index out of range");

  // Reduction ends below 2pi
  a_wrap_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.wrap_step && sts.wrap_last) |=> (rem < Q_TWO_PI))
    else $error("angle wrap left remainder of 2pi or more");
`endif

endmodule

FILE: hdl/joint_slew_rate_tracker.sv
// ----------------------------------------------------------------------------
// joint_slew_rate_tracker
// Multi-joint Q8.24 position tracker with a per-tick slew limit.
// ----------------------------------------------------------------------------
// Input stream (s_*): tuser is the opcode. A load (opcode 0) wraps goal_angle
// into [-pi,pi) and sets that joint's target on the shorter arc from its
// position; a load for a joint at or above JOINT_COUNT is dropped. A tick
// (opcode 1) sums the absolute joint errors; within reach_tolerance it
// reports every joint with zero velocity and reached set, otherwise it moves
// each joint by at most step_limit and reports position and velocity
// (step times ticks_per_second), both saturated.
// Result stream (m_*): one transfer per joint, joints in order, tlast on the
// final joint, tuser = reached.
// Sequencing: one item at a time. A load passes through accept, six restoring
// steps of the modulo-2pi unit and the target write. A tick passes through
// accept, the error sum over the joints and the reached test, then step,
// multiply and transfer per joint when moving, or only the transfer per
// joint when reached. The receiver can stall the walk: the single result
// register holds each result until taken, and the walk waits.
// The next item is accepted once the last result is loaded.
// Reset: positions and targets zero, registers to their defaults, no result
// pending. Configuration writes are taken in any cycle (cfg_ready is high).
// ----------------------------------------------------------------------------
module joint_slew_rate_tracker
  import jsrt_pkg::*;
#(
  parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // joint[2:0], goal_angle[34:3], zero pad
  input  logic                   s_tuser,   // opcode
  // Result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // joint_index[2:0], position[34:3],
                                            // velocity[66:35], zero pad
  output logic                   m_tuser,   // reached
  output logic                   m_tlast
);

  cmd_t cmd;
  sts_t sts;

  jsrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jsrt_dp #(
    .JOINT_COUNT (JOINT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: tb/sv/joint_slew_rate_tracker_test.sv
// ----------------------------------------------------------------------------
// joint_slew_rate_tracker_test
// Self-checking testbench for the multi-joint slew-rate tracker. Goal loads
// and ticks are pushed through the input stream, and a mirror of the joint
// positions, targets and velocities predicts every joint report of a tick.
// Reports are compared field by field in order. A directed opening covers
// the angle extremes, the wrap at +/-pi, dropped joints, saturated
// velocities, a zero tick rate and the register extremes. Random goal
// sequences then follow under several register settings, with random idle
// on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module joint_slew_rate_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jsrt_pkg::*;

  localparam int     JOINTS    = 6;
  localparam longint HALF_TURN = 52707179;
  localparam longint FULL_TURN = 105414357;
  localparam longint S32_MAX   = 64'sh7FFF_FFFF;
  localparam longint S32_MIN   = -64'sh8000_0000;

  typedef struct packed {
    opcode_t     op;
    logic [2:0]  joint;
    logic [31:0] goal;
  } command_t;

  typedef struct packed {
    logic [2:0]         joint_index;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic               reached;
    logic               last;
  } joint_report_t;

  // DUT connections
  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // joint[2:0], goal_angle[34:3], zero pad
  logic                   s_tuser   = 1'b0; // opcode
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // joint_index[2:0], position[34:3],
                                            // velocity[66:35], zero pad
  logic                   m_tuser;          // reached
  logic                   m_tlast;

  // Mirror of the tracker state and registers
  logic signed [31:0] pos_m [JOINTS];
  logic signed [31:0] vel_m [JOINTS];
  logic signed [31:0] tgt_m [JOINTS];
  logic               active_m  = 1'b0;
  logic [30:0]        step_cap  = 31'd167772;
  logic [19:0]        tick_rate = 20'd1000;
  logic [30:0]        reach_tol = 31'd167772;

  command_t      motion_q [$];
  joint_report_t pose_q [$];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  in_pause     = 0;
  int  out_pause    = 0;
  bit  in_taken     = 1'b0;
  bit  out_taken    = 1'b0;
  bit  calm         = 1'b0;
  bit  choke        = 1'b0;

  joint_slew_rate_tracker #(.JOINT_COUNT(JOINTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    for (int i = 0; i < JOINTS; i++) begin
      pos_m[i] = '0;
      vel_m[i] = '0;
      tgt_m[i] = '0;
    end
  end

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > S32_MAX) return S32_MAX[31:0];
    if (v < S32_MIN) return S32_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic int pause_len();
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [31:0] random_goal();
    logic [31:0] rim;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        // hug the wrap point at +/-pi
        rim = $urandom_range(0, 1) ? 32'(HALF_TURN) : -32'(HALF_TURN);
        return rim + $urandom_range(0, 8) - 32'd4;
      end
      default: return $urandom_range(0, 2 * FULL_TURN) - 32'(FULL_TURN);
    endcase
  endfunction

  task automatic report_bad(string what, joint_report_t want, joint_report_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want joint %0d pos %0d vel %0d reached %0b last %0b",
               $time, what, want.joint_index, want.position, want.velocity,
               want.reached, want.last,
               "; got joint %0d pos %0d vel %0d reached %0b last %0b",
               seen.joint_index, seen.position, seen.velocity, seen.reached,
               seen.last);
  endtask

  task automatic queue_cmd(opcode_t op, logic [2:0] j, logic [31:0] g);
    command_t c;
    c.op    = op;
    c.joint = j;
    c.goal  = g;
    motion_q.push_back(c);
  endtask

  // Write one register while the block is idle and mirror it
  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STEP_LIMIT: step_cap  = value[30:0];
      CFG_TICK_RATE:  tick_rate = value[19:0];
      CFG_REACH_TOL:  reach_tol = value[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for all commands and reports, then let a trailing load finish
  task automatic settle();
    while (motion_q.size() != 0 || s_tvalid || pose_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Goal sequences with random content, broken up by the odd stray item
  task automatic random_phase(int count);
    int       left;
    int       n;
    opcode_t  op;
    logic [2:0] j;
    left = count;
    while (left > 0) begin
      while (motion_q.size() != 0) @(posedge clk);
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        op = opcode_t'($urandom_range(0, 1));
        j  = 3'($urandom);
        queue_cmd(op, j, $urandom);
        if (!(op == OP_LOAD && j >= JOINTS)) left--;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) queue_cmd(OP_LOAD, 3'($urandom_range(0, JOINTS - 1)), random_goal());
        left -= n;
        n = $urandom_range(1, 5);
        repeat (n) queue_cmd(OP_TICK, 3'($urandom), $urandom);
        left -= n;
      end
    end
    settle();
  endtask

  // Offer commands; hold each until its transfer, then idle as drawn
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (in_pause > 0) begin
        in_pause--;
        s_tvalid <= 1'b0;
      end else if (motion_q.size() > 0) begin
        s_tuser  <= motion_q[0].op;
        s_tdata  <= {5'b0, motion_q[0].goal, motion_q[0].joint};
        s_tvalid <= 1'b1;
        void'(motion_q.pop_front());
        in_pause = pause_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Advance the mirror on each accepted command
  always @(posedge clk) begin : predict_motion
    longint goal, near, diff, sum, err, d;
    logic [2:0]    j;
    logic          done;
    joint_report_t rep;
    if (!rst && s_tvalid && s_tready) begin
      in_taken = 1'b1;
      j = s_tdata[2:0];
      if (s_tuser == OP_LOAD) begin
        if (j < JOINTS) begin
          // wrap into [-pi,pi) with floor modulo
          goal = (longint'($signed(s_tdata[34:3])) + HALF_TURN) % FULL_TURN;
          if (goal < 0) goal += FULL_TURN;
          goal -= HALF_TURN;
          // pick the shorter arc from the current position
          diff = goal - longint'(pos_m[j]);
          if (diff > HALF_TURN) near = goal - FULL_TURN;
          else if (diff < -HALF_TURN) near = goal + FULL_TURN;
          else near = goal;
          tgt_m[j] = clamp32(near);
          active_m = 1'b1;
        end
      end else begin
        sum = 0;
        for (int i = 0; i < JOINTS; i++) begin
          err = longint'(tgt_m[i]) - longint'(pos_m[i]);
          sum += (err < 0) ? -err : err;
        end
        done = (sum <= longint'(reach_tol));
        for (int i = 0; i < JOINTS; i++) begin
          if (done) begin
            vel_m[i] = '0;
          end else begin
            err = longint'(tgt_m[i]) - longint'(pos_m[i]);
            if (err > longint'(step_cap)) d = longint'(step_cap);
            else if (err < -longint'(step_cap)) d = -longint'(step_cap);
            else d = err;
            d = longint'(clamp32(longint'(pos_m[i]) + d)) - longint'(pos_m[i]);
            pos_m[i] = clamp32(longint'(pos_m[i]) + d);
            vel_m[i] = clamp32(d * longint'(tick_rate));
          end
          rep.joint_index = 3'(i);
          rep.position    = pos_m[i];
          rep.velocity    = vel_m[i];
          rep.reached     = done;
          rep.last        = (i == JOINTS - 1);
          pose_q.push_back(rep);
        end
        if (done) active_m = 1'b0;
      end
    end
  end

  // Take reports, stalling as drawn or while held off
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      out_pause = pause_len();
    end
    if (rst || choke) begin
      m_tready <= 1'b0;
    end else if (out_pause > 0) begin
      out_pause--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check each report transfer against the oldest prediction
  always @(posedge clk) begin : check_reports
    joint_report_t seen;
    joint_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      out_taken = 1'b1;
      results_seen++;
      seen.joint_index = m_tdata[2:0];
      seen.position    = m_tdata[34:3];
      seen.velocity    = m_tdata[66:35];
      seen.reached     = m_tuser;
      seen.last        = m_tlast;
      if (pose_q.size() == 0) begin
        report_bad("unexpected report", '0, seen);
      end else begin
        want = pose_q.pop_front();
        if (seen.joint_index != want.joint_index || seen.position != want.position ||
            seen.velocity != want.velocity || seen.reached != want.reached ||
            seen.last != want.last)
          report_bad("report mismatch", want, seen);
      end
    end
  end

  // Long receiver hold-off while commands keep coming, so the input stalls
  initial begin
    wait (results_seen >= 90);
    @(posedge clk);
    choke = 1'b1;
    repeat (300) @(posedge clk);
    choke = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Huge step, top tick rate, zero tolerance; the bit above the step field drops
    write_reg(CFG_STEP_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_TICK_RATE, 32'h000F_FFFF);
    write_reg(CFG_REACH_TOL, 32'd0);
    queue_cmd(OP_TICK, 3'd0, 32'd0);              // nothing loaded: reached at once
    queue_cmd(OP_LOAD, 3'd0, 32'h7FFF_FFFF);
    queue_cmd(OP_LOAD, 3'd1, 32'h8000_0000);
    queue_cmd(OP_LOAD, 3'd2, 32'(HALF_TURN));     // +pi wraps round to -pi
    queue_cmd(OP_LOAD, 3'd3, -32'(HALF_TURN));
    queue_cmd(OP_LOAD, 3'd4, 32'(HALF_TURN - 1));
    queue_cmd(OP_LOAD, 3'd5, 32'(-HALF_TURN - 1));
    queue_cmd(OP_LOAD, 3'd6, 32'd12345);          // joints past the last are dropped
    queue_cmd(OP_LOAD, 3'd7, 32'hFFFF_FFFF);
    queue_cmd(OP_TICK, 3'd7, 32'hFFFF_FFFF);      // whole error in one step, velocity saturates
    queue_cmd(OP_TICK, 3'd0, 32'd0);
    queue_cmd(OP_LOAD, 3'd2, 32'(HALF_TURN / 2)); // long way round from -pi: target below -pi
    queue_cmd(OP_LOAD, 3'd5, 32'h4000_0000);
    queue_cmd(OP_TICK, 3'd5, 32'h5555_5555);
    queue_cmd(OP_TICK, 3'd2, 32'hAAAA_AAAA);
    settle();

    // Zero step, widest tolerance: every tick reports reached
    write_reg(CFG_STEP_LIMIT, 32'd0);
    write_reg(CFG_TICK_RATE, 32'd1);
    write_reg(CFG_REACH_TOL, 32'h7FFF_FFFF);
    queue_cmd(OP_LOAD, 3'd3, random_goal());
    queue_cmd(OP_TICK, 3'd0, 32'd0);
    queue_cmd(OP_LOAD, 3'd0, 32'h8000_0000);
    queue_cmd(OP_TICK, 3'd0, 32'd0);
    settle();

    // Zero tick rate: joints move but report no velocity
    write_reg(CFG_STEP_LIMIT, 32'd30_000_000);
    write_reg(CFG_TICK_RATE, 32'd0);
    write_reg(CFG_REACH_TOL, 32'd0);
    queue_cmd(OP_LOAD, 3'd0, 32'(HALF_TURN - 1));
    queue_cmd(OP_LOAD, 3'd4, 32'd0);
    repeat (3) queue_cmd(OP_TICK, 3'd0, 32'd0);
    settle();

    // Random sequences under several settings
    write_reg(CFG_STEP_LIMIT, $urandom_range(20_000_000, 120_000_000));
    write_reg(CFG_TICK_RATE, $urandom_range(1, 1_000_000));
    write_reg(CFG_REACH_TOL, $urandom_range(0, 40_000_000));
    random_phase(25);

    write_reg(CFG_STEP_LIMIT, 32'd167772);
    write_reg(CFG_TICK_RATE, 32'd1000);
    write_reg(CFG_REACH_TOL, 32'd167772);
    random_phase(15);

    write_reg(CFG_STEP_LIMIT, $urandom_range(20_000_000, 120_000_000));
    write_reg(CFG_TICK_RATE, $urandom_range(1, 1_000_000));
    write_reg(CFG_REACH_TOL, $urandom_range(0, 40_000_000));
    random_phase(30);

    write_reg(CFG_STEP_LIMIT, 32'h7FFF_FFFF);
    write_reg(CFG_TICK_RATE, 32'd1_000_000);
    write_reg(CFG_REACH_TOL, $urandom_range(0, 40_000_000));
    random_phase(25);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/jsrt_pkg.sv
hdl/jsrt_ctrl.sv
hdl/jsrt_dp.sv
hdl/joint_slew_rate_tracker.sv
tb/sv/joint_slew_rate_tracker_test.sv
